// ----- rtl/spectral_peak_parabolic_interp_assert.svh -----
// Assertion macros used by the snapshot queue of the peak interpolator RTL.
`ifndef SPECTRAL_PEAK_PARABOLIC_INTERP_ASSERT_SVH
`define SPECTRAL_PEAK_PARABOLIC_INTERP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/spi_pkg.sv -----
// Shared types, constants and constant tables of the peak interpolator.
package spi_pkg;

    localparam int MAX_POINTS = 4096;
    localparam logic [11:0] IDX_LAST = 12'(MAX_POINTS - 1);

    localparam logic signed [19:0] DB_MIN = 20'sh80000;
    localparam logic signed [19:0] DB_MAX = 20'sh7FFFF;
    localparam logic signed [27:0] DB_K = 28'sd101008905;
    localparam logic signed [31:0] LOG_OFS = 32'sd402653184;
    localparam logic [23:0] FREQ_MAX = 24'hFFFFFF;
    localparam logic [21:0] OFF_MAX = 22'h200000;

    typedef struct packed {
        logic [31:0] best_mag;
        logic [23:0] best_freq;
        logic [11:0] best_pos;
        logic [31:0] before_mag;
        logic [23:0] before_freq;
        logic [31:0] after_mag;
        logic [23:0] after_freq;
        logic        fit;
    } t_snap;

    typedef struct packed {
        logic        start;
        logic        frac24;
        logic [31:0] x;
    } t_log_req;

    typedef struct packed {
        logic         start;
        logic         div;
        logic [127:0] a;
        logic [63:0]  b;
    } t_mdu_req;

    typedef logic [11:0][31:0] t_exp_tab;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] bitv;
        int i;
        rem = v;
        r = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (i = 0; i < 32; i++) begin
            if (rem >= r + bitv) begin
                rem = rem - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // Factors 2^(2^-i) in Q30, i = 1..12.
    function automatic t_exp_tab exp_table();
        t_exp_tab t;
        logic [63:0] s;
        int i;
        s = isqrt64(64'h2000_0000_0000_0000);
        for (i = 0; i < 12; i++) begin
            t[i] = s[31:0];
            s = isqrt64(s << 30);
        end
        return t;
    endfunction

    localparam t_exp_tab EXP_S = exp_table();

endpackage

// ----- rtl/spi_front.sv -----
// Front end: running peak search over the burst, snapshot on the last point.
module spi_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [23:0]         i_freq,
    input  logic [31:0]         i_magnitude,
    input  logic                i_last_point,
    input  logic                i_full,
    output logic                o_stall,
    output logic                o_push,
    output spi_pkg::t_snap      o_snap
);

    logic [31:0] r_best_mag, r_before_mag, r_after_mag, r_prior_mag;
    logic [23:0] r_best_freq, r_before_freq, r_after_freq, r_prior_freq;
    logic [11:0] r_best_pos, r_count;
    logic        r_after_seen;

    logic [31:0] n_best_mag, n_before_mag, n_after_mag;
    logic [23:0] n_best_freq, n_before_freq, n_after_freq;
    logic [11:0] n_best_pos, n_count;
    logic        n_after_seen;
    logic        w_acc;

    assign w_acc   = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = w_acc && i_last_point;

    always_comb begin
        n_best_mag    = r_best_mag;
        n_best_freq   = r_best_freq;
        n_best_pos    = r_best_pos;
        n_before_mag  = r_before_mag;
        n_before_freq = r_before_freq;
        n_after_mag   = r_after_mag;
        n_after_freq  = r_after_freq;
        n_after_seen  = r_after_seen;
        if (r_count == '0 || i_magnitude > r_best_mag) begin
            n_before_mag  = r_prior_mag;
            n_before_freq = r_prior_freq;
            n_best_mag    = i_magnitude;
            n_best_freq   = i_freq;
            n_best_pos    = r_count;
            n_after_seen  = 1'b0;
        end else if (!r_after_seen) begin
            n_after_mag  = i_magnitude;
            n_after_freq = i_freq;
            n_after_seen = 1'b1;
        end
        n_count = (r_count < spi_pkg::IDX_LAST) ? r_count + 12'd1 : r_count;
    end

    always_comb begin
        o_snap.best_mag    = n_best_mag;
        o_snap.best_freq   = n_best_freq;
        o_snap.best_pos    = n_best_pos;
        o_snap.before_mag  = n_before_mag;
        o_snap.before_freq = n_before_freq;
        o_snap.after_mag   = n_after_mag;
        o_snap.after_freq  = n_after_freq;
        o_snap.fit         = (n_best_pos != '0) && n_after_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_best_mag    <= '0;
            r_best_freq   <= '0;
            r_best_pos    <= '0;
            r_before_mag  <= '0;
            r_before_freq <= '0;
            r_after_mag   <= '0;
            r_after_freq  <= '0;
            r_after_seen  <= 1'b0;
            r_prior_mag   <= '0;
            r_prior_freq  <= '0;
            r_count       <= '0;
        end else if (w_acc) begin
            r_best_mag    <= n_best_mag;
            r_best_freq   <= n_best_freq;
            r_best_pos    <= n_best_pos;
            r_before_mag  <= n_before_mag;
            r_before_freq <= n_before_freq;
            r_after_mag   <= n_after_mag;
            r_after_freq  <= n_after_freq;
            r_after_seen  <= n_after_seen;
            r_prior_mag   <= i_magnitude;
            r_prior_freq  <= i_freq;
            r_count       <= n_count;
        end
    end

endmodule

// ----- rtl/spi_fifo.sv -----
// Two-entry queue of burst snapshots between front and back end.
`include "spectral_peak_parabolic_interp_assert.svh"

module spi_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spi_pkg::t_snap i_data,
    input  logic           i_pop,
    output spi_pkg::t_snap o_data,
    output logic           o_full,
    output logic           o_empty
);

    spi_pkg::t_snap r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_count;

    assign o_data  = r_mem[r_rp];
    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    `SPI_ASSERT_IMP(a_push_not_full, i_push, !o_full, "push into full queue")
    `SPI_ASSERT_IMP(a_pop_not_empty, i_pop, !o_empty, "pop from empty queue")
    `SPI_ASSERT_NXT(a_push_fills, i_push && !i_pop, !o_empty, "pushed item lost")
    `SPI_ASSERT_IMP(a_count_range, 1'b1, r_count != 2'd3, "queue count out of range")

endmodule

// ----- rtl/spi_log2.sv -----
// Iterative fixed-point log2: shift normalize, then one squaring per fraction bit.
module spi_log2 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spi_pkg::t_log_req i_req,
    output logic              o_done,
    output logic [28:0]       o_res
);

    logic        r_busy, r_norm, r_f24, r_done;
    logic [31:0] r_y;
    logic [4:0]  r_p, r_cnt;
    logic [23:0] r_frac;
    logic [63:0] w_sq;
    logic [32:0] w_t;

    assign w_sq   = r_y * r_y;
    assign w_t    = w_sq[63:31];
    assign o_done = r_done;
    assign o_res  = r_f24 ? {r_p, r_frac} : {12'b0, r_p, r_frac[11:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_norm <= 1'b1;
                r_f24  <= i_req.frac24;
                r_y    <= (i_req.x == '0) ? 32'd1 : i_req.x;
                r_p    <= 5'd31;
                r_cnt  <= i_req.frac24 ? 5'd24 : 5'd12;
                r_frac <= '0;
            end else if (r_busy) begin
                if (r_norm) begin
                    if (r_y[31]) begin
                        r_norm <= 1'b0;
                    end else begin
                        r_y <= r_y << 1;
                        r_p <= r_p - 5'd1;
                    end
                end else if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_y    <= w_t[32] ? w_t[32:1] : w_t[31:0];
                    r_frac <= {r_frac[22:0], w_t[32]};
                    r_cnt  <= r_cnt - 5'd1;
                end
            end
        end
    end

endmodule

// ----- rtl/spi_mdu.sv -----
// Serial multiply (64x64, bit a cycle) and restoring divide (128/64) unit.
module spi_mdu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spi_pkg::t_mdu_req i_req,
    output logic              o_done,
    output logic [127:0]      o_res
);

    logic         r_busy, r_div, r_done;
    logic [6:0]   r_cnt;
    logic [127:0] r_acc;
    logic [63:0]  r_rem, r_b;
    logic [64:0]  w_sum, w_rr, w_diff;
    logic         w_ge;

    assign w_sum  = {1'b0, r_acc[127:64]} + (r_acc[0] ? {1'b0, r_b} : 65'd0);
    assign w_rr   = {r_rem, r_acc[127]};
    assign w_ge   = w_rr >= {1'b0, r_b};
    assign w_diff = w_rr - {1'b0, r_b};
    assign o_done = r_done;
    assign o_res  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_div  <= i_req.div;
                r_cnt  <= '0;
                r_acc  <= i_req.a;
                r_rem  <= '0;
                r_b    <= i_req.b;
            end else if (r_busy) begin
                if (r_div) begin
                    r_acc <= {r_acc[126:0], w_ge};
                    r_rem <= w_ge ? w_diff[63:0] : w_rr[63:0];
                end else begin
                    r_acc <= {w_sum, r_acc[63:1]};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == (r_div ? 7'd127 : 7'd63)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/spi_back.sv -----
// Back end: dB conversion, parabolic fit, vertex level and frequency per burst.
module spi_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  spi_pkg::t_snap       i_snap,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [19:0]   o_raw_db,
    output logic [23:0]          o_raw_freq,
    output logic [11:0]          o_peak_index,
    output logic signed [19:0]   o_interp_db,
    output logic [23:0]          o_interp_freq,
    output logic                 o_interpolated
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LOGGO = 5'd1;
    localparam logic [4:0] S_LOGW  = 5'd2;
    localparam logic [4:0] S_DBMUL = 5'd3;
    localparam logic [4:0] S_DBRND = 5'd4;
    localparam logic [4:0] S_NEXT  = 5'd5;
    localparam logic [4:0] S_MUL   = 5'd6;
    localparam logic [4:0] S_MULW  = 5'd7;
    localparam logic [4:0] S_CHK   = 5'd8;
    localparam logic [4:0] S_SQ    = 5'd9;
    localparam logic [4:0] S_SQW   = 5'd10;
    localparam logic [4:0] S_D1    = 5'd11;
    localparam logic [4:0] S_D1W   = 5'd12;
    localparam logic [4:0] S_D2    = 5'd13;
    localparam logic [4:0] S_D2W   = 5'd14;
    localparam logic [4:0] S_OFF   = 5'd15;
    localparam logic [4:0] S_FREQ  = 5'd16;
    localparam logic [4:0] S_FDW   = 5'd17;
    localparam logic [4:0] S_XP    = 5'd18;
    localparam logic [4:0] S_EXP   = 5'd19;
    localparam logic [4:0] S_EXPF  = 5'd20;
    localparam logic [4:0] S_OUT   = 5'd21;

    localparam logic [2:0] J_Y1 = 3'd0;
    localparam logic [2:0] J_Y0 = 3'd1;
    localparam logic [2:0] J_Y2 = 3'd2;
    localparam logic [2:0] J_X1 = 3'd3;
    localparam logic [2:0] J_X0 = 3'd4;
    localparam logic [2:0] J_X2 = 3'd5;

    localparam logic [2:0] OP_QA  = 3'd0;
    localparam logic [2:0] OP_PB  = 3'd1;
    localparam logic [2:0] OP_AB  = 3'd2;
    localparam logic [2:0] OP_DD  = 3'd3;
    localparam logic [2:0] OP_T1A = 3'd4;
    localparam logic [2:0] OP_T2B = 3'd5;

    logic [4:0]          r_state;
    spi_pkg::t_snap      r_snap;
    logic [2:0]          r_job, r_op;
    logic signed [19:0]  r_y0, r_y1, r_y2;
    logic [16:0]         r_x0, r_x1, r_x2;
    logic signed [59:0]  r_prod;
    logic signed [63:0]  r_t1, r_t2, r_ab, r_u, r_nn, r_dd, r_mm;
    logic                r_mneg, r_dneg;
    logic [127:0]        r_wide;
    logic signed [41:0]  r_xp;
    logic [4:0]          r_k;
    logic [11:0]         r_f;
    logic [31:0]         r_er;
    logic [3:0]          r_ecnt;
    logic signed [19:0]  r_idb;
    logic [23:0]         r_ifr;
    logic                r_flag;
    logic                r_ov;
    logic signed [19:0]  r_o_raw_db, r_o_interp_db;
    logic [23:0]         r_o_raw_freq, r_o_interp_freq;
    logic [11:0]         r_o_peak_index;
    logic                r_o_interpolated;

    spi_pkg::t_log_req   w_lreq;
    spi_pkg::t_mdu_req   w_mreq;
    logic                w_ldone, w_mdone;
    logic [28:0]         w_lres;
    logic [127:0]        w_mres;

    logic [31:0]         w_lx;
    logic                w_lzero, w_dbjob;
    logic signed [31:0]  w_l;
    logic [59:0]         w_pm;
    logic [19:0]         w_rm;
    logic signed [19:0]  w_ydb;
    logic signed [17:0]  w_a, w_b;
    logic signed [18:0]  w_bma;
    logic signed [20:0]  w_p, w_q, w_yd;
    logic signed [21:0]  w_den;
    logic signed [63:0]  w_opa, w_opb, w_sres;
    logic [63:0]         w_ma, w_mb, w_mmm, w_ddm, w_nnm;
    logic [20:0]         w_ydm;
    logic [21:0]         w_denm;
    logic [33:0]         w_fdiv;
    logic [39:0]         w_quot;
    logic signed [41:0]  w_delta;
    logic [21:0]         w_off;
    logic signed [22:0]  w_val;
    logic [63:0]         w_emul;
    logic [55:0]         w_esh;
    logic [25:0]         w_v;
    logic [23:0]         w_vc;

    spi_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_lreq),
        .o_done  (w_ldone),
        .o_res   (w_lres)
    );

    spi_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    always_comb begin
        case (r_job)
            J_Y1:    w_lx = r_snap.best_mag;
            J_Y0:    w_lx = r_snap.before_mag;
            J_Y2:    w_lx = r_snap.after_mag;
            J_X1:    w_lx = {8'b0, r_snap.best_freq};
            J_X0:    w_lx = {8'b0, r_snap.before_freq};
            default: w_lx = {8'b0, r_snap.after_freq};
        endcase
    end

    assign w_dbjob = r_job < J_X1;
    assign w_lzero = w_lx == '0;

    assign w_l   = $signed({3'b0, w_lres}) - spi_pkg::LOG_OFS;
    assign w_pm  = r_prod[59] ? 60'(-r_prod) : 60'(r_prod);
    assign w_rm  = 20'((w_pm + 60'h80_0000_0000) >> 40);
    assign w_ydb = r_prod[59] ? -$signed(w_rm) : $signed(w_rm);

    assign w_a   = $signed({1'b0, r_x0}) - $signed({1'b0, r_x1});
    assign w_b   = $signed({1'b0, r_x2}) - $signed({1'b0, r_x1});
    assign w_bma = 19'(w_b) - 19'(w_a);
    assign w_p   = 21'(r_y0) - 21'(r_y1);
    assign w_q   = 21'(r_y2) - 21'(r_y1);
    assign w_yd  = 21'(r_y0) - 21'(r_y2);
    assign w_den = 22'(w_p) + 22'(w_q);

    always_comb begin
        case (r_op)
            OP_QA:   begin w_opa = 64'(w_q);  w_opb = 64'(w_a);   end
            OP_PB:   begin w_opa = 64'(w_p);  w_opb = 64'(w_b);   end
            OP_AB:   begin w_opa = 64'(w_a);  w_opb = 64'(w_b);   end
            OP_DD:   begin w_opa = r_ab;      w_opb = 64'(w_bma); end
            OP_T1A:  begin w_opa = r_t1;      w_opb = 64'(w_a);   end
            default: begin w_opa = r_t2;      w_opb = 64'(w_b);   end
        endcase
    end

    assign w_ma   = w_opa[63] ? 64'(-w_opa) : 64'(w_opa);
    assign w_mb   = w_opb[63] ? 64'(-w_opb) : 64'(w_opb);
    assign w_mmm  = r_mm[63] ? 64'(-r_mm) : 64'(r_mm);
    assign w_ddm  = r_dd[63] ? 64'(-r_dd) : 64'(r_dd);
    assign w_nnm  = r_nn[63] ? 64'(-r_nn) : 64'(r_nn);
    assign w_sres = r_mneg ? -$signed(w_mres[63:0]) : $signed(w_mres[63:0]);

    assign w_ydm  = w_yd[20] ? 21'(-w_yd) : 21'(w_yd);
    assign w_denm = w_den[21] ? 22'(-w_den) : 22'(w_den);
    assign w_fdiv = 34'({w_ydm, 11'b0}) + 34'(w_denm >> 1);
    assign w_quot = w_mres[39:0];
    assign w_delta = r_dneg ? -$signed({2'b0, w_quot}) : $signed({2'b0, w_quot});

    assign w_off = (r_wide[127:22] == '0 && r_wide[21:0] <= spi_pkg::OFF_MAX)
                   ? r_wide[21:0] : spi_pkg::OFF_MAX;
    assign w_val = 23'(r_y1) + $signed({1'b0, w_off});

    assign w_emul = r_er * spi_pkg::EXP_S[r_ecnt];
    assign w_esh  = 56'(r_er) << r_k;
    assign w_v    = 26'((w_esh + 56'd536870912) >> 30);
    assign w_vc   = (w_v == '0) ? 24'd1 :
                    (w_v > 26'(spi_pkg::FREQ_MAX)) ? spi_pkg::FREQ_MAX : w_v[23:0];

    always_comb begin
        w_lreq.start  = (r_state == S_LOGGO) && !(w_dbjob && w_lzero);
        w_lreq.frac24 = w_dbjob;
        w_lreq.x      = w_lx;
    end

    always_comb begin
        w_mreq = '0;
        case (r_state)
            S_MUL: begin
                w_mreq.start = 1'b1;
                w_mreq.a     = {64'b0, w_ma};
                w_mreq.b     = w_mb;
            end
            S_SQ: begin
                w_mreq.start = 1'b1;
                w_mreq.a     = {64'b0, w_mmm};
                w_mreq.b     = w_mmm;
            end
            S_D1: begin
                w_mreq.start = 1'b1;
                w_mreq.div   = 1'b1;
                w_mreq.a     = r_wide;
                w_mreq.b     = {w_ddm[61:0], 2'b00};
            end
            S_D2: begin
                w_mreq.start = 1'b1;
                w_mreq.div   = 1'b1;
                w_mreq.a     = r_wide;
                w_mreq.b     = w_nnm;
            end
            S_FREQ: begin
                w_mreq.start = w_den != '0;
                w_mreq.div   = 1'b1;
                w_mreq.a     = 128'(w_fdiv);
                w_mreq.b     = 64'(w_denm);
            end
            default: ;
        endcase
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ov || !i_stall)) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_snap  <= i_snap;
                        r_job   <= J_Y1;
                        r_ifr   <= i_snap.best_freq;
                        r_flag  <= 1'b0;
                        r_state <= S_LOGGO;
                    end
                end
                S_LOGGO: begin
                    if (w_dbjob && w_lzero) begin
                        case (r_job)
                            J_Y1:    r_y1 <= spi_pkg::DB_MIN;
                            J_Y0:    r_y0 <= spi_pkg::DB_MIN;
                            default: r_y2 <= spi_pkg::DB_MIN;
                        endcase
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_LOGW;
                    end
                end
                S_LOGW: begin
                    if (w_ldone) begin
                        if (w_dbjob) begin
                            r_state <= S_DBMUL;
                        end else begin
                            case (r_job)
                                J_X1:    r_x1 <= w_lres[16:0];
                                J_X0:    r_x0 <= w_lres[16:0];
                                default: r_x2 <= w_lres[16:0];
                            endcase
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_DBMUL: begin
                    r_prod  <= 60'(w_l * spi_pkg::DB_K);
                    r_state <= S_DBRND;
                end
                S_DBRND: begin
                    case (r_job)
                        J_Y1:    r_y1 <= w_ydb;
                        J_Y0:    r_y0 <= w_ydb;
                        default: r_y2 <= w_ydb;
                    endcase
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_job == J_Y1 && !r_snap.fit) begin
                        r_idb   <= r_y1;
                        r_state <= S_OUT;
                    end else if (r_job == J_X2) begin
                        r_op    <= OP_QA;
                        r_state <= S_MUL;
                    end else begin
                        r_job   <= r_job + 3'd1;
                        r_state <= S_LOGGO;
                    end
                end
                S_MUL: begin
                    r_mneg  <= w_opa[63] ^ w_opb[63];
                    r_state <= S_MULW;
                end
                S_MULW: begin
                    if (w_mdone) begin
                        case (r_op)
                            OP_QA:  r_t1 <= w_sres;
                            OP_PB: begin
                                r_t2 <= w_sres;
                                r_nn <= r_t1 - w_sres;
                            end
                            OP_AB:  r_ab <= w_sres;
                            OP_DD:  r_dd <= w_sres;
                            OP_T1A: r_u  <= w_sres;
                            default: r_mm <= r_u - w_sres;
                        endcase
                        if (r_op == OP_T2B) begin
                            r_state <= S_CHK;
                        end else begin
                            r_op    <= r_op + 3'd1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_CHK: begin
                    r_idb <= r_y1;
                    if (r_nn == '0 || r_dd == '0 || r_mm == '0) begin
                        r_state <= S_FREQ;
                    end else if (r_dd[63] != r_nn[63]) begin
                        r_state <= S_SQ;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SQ:  r_state <= S_SQW;
                S_SQW: begin
                    if (w_mdone) begin
                        r_wide  <= w_mres;
                        r_state <= S_D1;
                    end
                end
                S_D1:  r_state <= S_D1W;
                S_D1W: begin
                    if (w_mdone) begin
                        r_wide  <= w_mres;
                        r_state <= S_D2;
                    end
                end
                S_D2:  r_state <= S_D2W;
                S_D2W: begin
                    if (w_mdone) begin
                        r_wide  <= w_mres;
                        r_state <= S_OFF;
                    end
                end
                S_OFF: begin
                    r_idb   <= (w_val > 23'(spi_pkg::DB_MAX)) ? spi_pkg::DB_MAX : w_val[19:0];
                    r_state <= S_FREQ;
                end
                S_FREQ: begin
                    r_flag <= 1'b1;
                    r_dneg <= w_yd[20] ^ w_den[21];
                    if (w_den == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_FDW;
                    end
                end
                S_FDW: begin
                    if (w_mdone) begin
                        r_xp    <= $signed({25'b0, r_x1}) + w_delta;
                        r_state <= S_XP;
                    end
                end
                S_XP: begin
                    if (r_xp[41]) begin
                        r_ifr   <= 24'd1;
                        r_state <= S_OUT;
                    end else if (r_xp >= 42'sd98304) begin
                        r_ifr   <= spi_pkg::FREQ_MAX;
                        r_state <= S_OUT;
                    end else begin
                        r_k     <= r_xp[16:12];
                        r_f     <= r_xp[11:0];
                        r_er    <= 32'h4000_0000;
                        r_ecnt  <= '0;
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (r_f[11]) begin
                        r_er <= w_emul[61:30];
                    end
                    r_f    <= r_f << 1;
                    r_ecnt <= r_ecnt + 4'd1;
                    if (r_ecnt == 4'd11) begin
                        r_state <= S_EXPF;
                    end
                end
                S_EXPF: begin
                    r_ifr   <= w_vc;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || !i_stall) begin
                        r_o_raw_db       <= r_y1;
                        r_o_raw_freq     <= r_snap.best_freq;
                        r_o_peak_index   <= r_snap.best_pos;
                        r_o_interp_db    <= r_idb;
                        r_o_interp_freq  <= r_flag ? r_ifr : r_snap.best_freq;
                        r_o_interpolated <= r_flag;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ov;
    assign o_raw_db       = r_o_raw_db;
    assign o_raw_freq     = r_o_raw_freq;
    assign o_peak_index   = r_o_peak_index;
    assign o_interp_db    = r_o_interp_db;
    assign o_interp_freq  = r_o_interp_freq;
    assign o_interpolated = r_o_interpolated;

endmodule

// ----- rtl/spectral_peak_parabolic_interp.sv -----
// Top level of the spectral peak picker with parabolic refinement.
// Throughput: one spectrum point per cycle; stall rises only while two finished bursts wait.
// The wait from the last point to its result is set by the iterative log2
// and, when the fit runs, also by the serial multiply/divide unit.
// Reset (synchronous, active low) clears the peak search, the queue and the output valid.
module spectral_peak_parabolic_interp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [23:0]         i_freq,
    input  logic [31:0]         i_magnitude,
    input  logic                i_last_point,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [19:0]  o_raw_db,
    output logic [23:0]         o_raw_freq,
    output logic [11:0]         o_peak_index,
    output logic signed [19:0]  o_interp_db,
    output logic [23:0]         o_interp_freq,
    output logic                o_interpolated
);

    spi_pkg::t_snap w_push_snap, w_pop_snap;
    logic           w_push, w_pop, w_full, w_empty;

    spi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_freq       (i_freq),
        .i_magnitude  (i_magnitude),
        .i_last_point (i_last_point),
        .i_full       (w_full),
        .o_stall      (o_in_stall),
        .o_push       (w_push),
        .o_snap       (w_push_snap)
    );

    spi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_snap),
        .i_pop   (w_pop),
        .o_data  (w_pop_snap),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    spi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_snap         (w_pop_snap),
        .o_pop          (w_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_raw_db       (o_raw_db),
        .o_raw_freq     (o_raw_freq),
        .o_peak_index   (o_peak_index),
        .o_interp_db    (o_interp_db),
        .o_interp_freq  (o_interp_freq),
        .o_interpolated (o_interpolated)
    );

endmodule

// ----- tb/sv/spectral_peak_parabolic_interp_tb.sv -----
// Testbench for the spectral peak picker: random bursts, self-checking against a local predictor.
module spectral_peak_parabolic_interp_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 4000;
    localparam int QUIET_LIMIT = 30000;
    localparam int TAIL_CYCLES = 1300;
    localparam int ITEM_TARGET = 850;
    localparam longint DB_GAIN = 101008905;

    typedef struct {
        logic [23:0] freq;
        logic [31:0] mag;
        logic        last;
        bit          drain;
        bit          hold;
        int          mode;
    } t_point;

    typedef struct {
        logic signed [19:0] raw_db;
        logic [23:0]        raw_freq;
        logic [11:0]        peak_index;
        logic signed [19:0] interp_db;
        logic [23:0]        interp_freq;
        logic               interpolated;
    } t_peak;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               o_in_stall;
    logic [23:0]        freq_d = '0;
    logic [31:0]        mag_d = '0;
    logic               last_d = 1'b0;
    logic               o_out_valid;
    logic               out_stall = 1'b0;
    logic signed [19:0] o_raw_db;
    logic [23:0]        o_raw_freq;
    logic [11:0]        o_peak_index;
    logic signed [19:0] o_interp_db;
    logic [23:0]        o_interp_freq;
    logic               o_interpolated;

    t_point point_q[$];
    t_peak  peak_expect_q[$];
    int     errors = 0;
    int     cur_mode = 0;
    bit     in_taken = 1'b0;
    bit     hold_req = 1'b0;
    bit     hold_used = 1'b0;
    int     hold_cnt = 0;
    int     quiet_cnt = 0;
    bit     gen_done = 1'b0;

    // predictor state
    logic [31:0] best_mag, before_mag, after_mag, prior_mag;
    logic [23:0] best_freq, before_freq, after_freq, prior_freq;
    logic [11:0] best_pos, pt_count;
    bit          after_seen;

    spectral_peak_parabolic_interp u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall),
        .i_freq(freq_d), .i_magnitude(mag_d), .i_last_point(last_d),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall),
        .o_raw_db(o_raw_db), .o_raw_freq(o_raw_freq), .o_peak_index(o_peak_index),
        .o_interp_db(o_interp_db), .o_interp_freq(o_interp_freq),
        .o_interpolated(o_interpolated)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint log2_q(logic [63:0] x, int fb);
        int p;
        int i;
        logic [63:0] y;
        logic [63:0] frac;
        if (x == 0) x = 1;
        p = 0;
        while (p < 63 && (x >> (p + 1)) != 0) p++;
        y = (p <= 31) ? (x << (31 - p)) : (x >> (p - 31));
        frac = 0;
        for (i = 0; i < fb; i++) begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= 64'h1_0000_0000) begin
                y = y >> 1;
                frac[0] = 1'b1;
            end
        end
        return longint'((64'(p) << fb) | frac);
    endfunction

    function automatic longint clamp_q(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mag_to_db(logic [31:0] m);
        longint l;
        logic [63:0] u;
        longint r;
        if (m == 0) return -524288;
        l = (log2_q(64'(m), 24) - (longint'(24) << 24)) * DB_GAIN;
        if (l >= 0) begin
            u = (64'(l) + (64'd1 << 39)) >> 40;
            r = longint'(u);
        end else begin
            u = (64'(-l) + (64'd1 << 39)) >> 40;
            r = -longint'(u);
        end
        return clamp_q(r, -524288, 524287);
    endfunction

    function automatic longint round_div(longint n, longint d);
        longint un;
        longint ud;
        longint r;
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        r = (un + ud / 2) / ud;
        return ((n < 0) != (d < 0)) ? -r : r;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [23:0] pow2_freq(longint xp);
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] v;
        int k;
        int i;
        if (xp < 0) return 24'd1;
        if (xp >= (longint'(24) << 12)) return spi_pkg::FREQ_MAX;
        k = int'(xp >> 12);
        r = 64'd1 << 30;
        s = root64(64'd1 << 61);
        for (i = 1; i <= 12; i++) begin
            if (xp[12 - i]) r = (r * s) >> 30;
            s = root64(s << 30);
        end
        v = ((r << k) + (64'd1 << 29)) >> 30;
        if (v < 1) v = 1;
        if (v > 64'(spi_pkg::FREQ_MAX)) v = 64'(spi_pkg::FREQ_MAX);
        return v[23:0];
    endfunction

    task automatic clear_search();
        best_mag = 0; best_freq = 0; best_pos = 0;
        before_mag = 0; before_freq = 0; after_mag = 0; after_freq = 0;
        prior_mag = 0; prior_freq = 0; pt_count = 0; after_seen = 0;
    endtask

    // Peak search and, on the last point, the refined peak.
    task automatic track_point(logic [23:0] f, logic [31:0] m, logic last);
        longint y0, y1, y2, x1, a, b, p, q, nn, dd, mm, val, idb;
        logic [23:0] ifr;
        logic [63:0] um, ud, un, off;
        logic [127:0] sq;
        bit accept;
        bit flag;
        t_peak r;
        if (pt_count == 0 || m > best_mag) begin
            before_mag = prior_mag; before_freq = prior_freq;
            best_mag = m; best_freq = f; best_pos = pt_count;
            after_seen = 0;
        end else if (!after_seen) begin
            after_mag = m; after_freq = f; after_seen = 1;
        end
        prior_mag = m; prior_freq = f;
        if (pt_count < spi_pkg::IDX_LAST) pt_count++;
        if (!last) return;
        y1 = mag_to_db(best_mag);
        idb = y1;
        ifr = best_freq;
        flag = 0;
        if (best_pos != 0 && after_seen) begin
            y0 = mag_to_db(before_mag);
            y2 = mag_to_db(after_mag);
            x1 = log2_q(64'(best_freq), 12);
            a = log2_q(64'(before_freq), 12) - x1;
            b = log2_q(64'(after_freq), 12) - x1;
            p = y0 - y1;
            q = y2 - y1;
            nn = q * a - p * b;
            dd = a * b * (b - a);
            mm = q * a * a - p * b * b;
            accept = 0;
            val = y1;
            if (nn == 0 || dd == 0 || mm == 0) begin
                accept = 1;
            end else if ((dd < 0) != (nn < 0)) begin
                um = 64'(mm < 0 ? -mm : mm);
                ud = 64'(dd < 0 ? -dd : dd);
                un = 64'(nn < 0 ? -nn : nn);
                sq = {64'd0, um} * {64'd0, um};
                sq = sq / {64'd0, 4 * ud};
                sq = sq / {64'd0, un};
                off = (sq > 128'(64'd1 << 21)) ? (64'd1 << 21) : sq[63:0];
                val = clamp_q(y1 + longint'(off), -524288, 524287);
                accept = 1;
            end
            if (accept) begin
                idb = val;
                flag = 1;
                if (p + q != 0) ifr = pow2_freq(x1 + round_div(2048 * (y0 - y2), p + q));
            end
        end
        r.raw_db = y1[19:0];
        r.raw_freq = best_freq;
        r.peak_index = best_pos;
        r.interp_db = idb[19:0];
        r.interp_freq = ifr;
        r.interpolated = flag;
        peak_expect_q.push_back(r);
        clear_search();
    endtask

    task automatic flag_mismatch(string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic add_point(logic [23:0] f, logic [31:0] m, logic last, int mode);
        t_point it;
        it.freq = f; it.mag = m; it.last = last;
        it.drain = 0; it.hold = 0; it.mode = mode;
        point_q.push_back(it);
    endtask

    task automatic add_marker(bit drain, bit hold, int mode);
        t_point it;
        it.freq = 0; it.mag = 0; it.last = 0;
        it.drain = drain; it.hold = hold; it.mode = mode;
        point_q.push_back(it);
    endtask

    // Shaped burst: rising frequencies, a peak with neighbors close below it.
    task automatic add_shaped(int len, int mode);
        int pk;
        int i;
        logic [31:0] pkmag;
        logic [31:0] m;
        logic [23:0] f;
        logic [23:0] stp;
        pk = $urandom_range(len - 1);
        pkmag = $urandom_range(32'hFFFF_FFFF, 32'h100);
        f = 24'($urandom_range(24'h0F_FFFF, 24'h10));
        stp = 24'($urandom_range(24'h2000, 1));
        for (i = 0; i < len; i++) begin
            if (i == pk) m = pkmag;
            else if (i == pk - 1 || i == pk + 1) m = pkmag - (pkmag >> $urandom_range(8, 1)) - 1;
            else m = $urandom_range(pkmag >> 2);
            if ($urandom_range(9) == 0 && i != pk) m = pkmag;
            add_point(f, m, i == len - 1, mode);
            f = (f > spi_pkg::FREQ_MAX - stp) ? spi_pkg::FREQ_MAX : f + stp;
        end
    endtask

    task automatic add_noise(int len, int mode);
        int i;
        logic [31:0] m;
        for (i = 0; i < len; i++) begin
            m = $urandom();
            if ($urandom_range(7) == 0) m = 0;
            add_point(24'($urandom_range(24'hFF_FFFF, 1)), m, i == len - 1, mode);
        end
    endtask

    initial begin
        int total;
        int mode;
        int i;
        // single point, zero and full-scale levels, extreme frequencies
        add_point(24'd1, 32'd0, 1'b1, 2);
        add_point(spi_pkg::FREQ_MAX, 32'hFFFF_FFFF, 1'b1, 2);
        // peak at either end
        add_point(24'd100, 32'h0200_0000, 1'b0, 2);
        add_point(24'd200, 32'h0100_0000, 1'b1, 2);
        add_point(24'd100, 32'h0100_0000, 1'b0, 2);
        add_point(24'd200, 32'h0200_0000, 1'b1, 2);
        // flat burst keeps the first maximum, so no fit is tried
        add_point(24'd160, 32'h0100_0000, 1'b0, 2);
        add_point(24'd320, 32'h0100_0000, 1'b0, 2);
        add_point(24'd640, 32'h0100_0000, 1'b1, 2);
        // symmetric and lopsided peaks
        add_point(24'd1600, 32'h0080_0000, 1'b0, 2);
        add_point(24'd3200, 32'h0100_0000, 1'b0, 2);
        add_point(24'd6400, 32'h0080_0000, 1'b1, 2);
        add_point(24'd1000, 32'h00F0_0000, 1'b0, 2);
        add_point(24'd1010, 32'h0100_0000, 1'b0, 2);
        add_point(24'd1020, 32'h0010_0000, 1'b1, 2);
        // wide spacing to push the fit toward rejection
        add_point(24'd2, 32'h0000_0001, 1'b0, 2);
        add_point(24'd3, 32'hFFFF_FFFF, 1'b0, 2);
        add_point(spi_pkg::FREQ_MAX, 32'hFFFF_FFFE, 1'b1, 2);
        add_marker(1, 0, 2);
        total = 18;
        mode = 0;
        while (total < ITEM_TARGET) begin
            if (mode == 0 && total > ITEM_TARGET / 3) begin
                add_marker(1, 0, 0);
                mode = 1;
            end else if (mode == 1 && total > 2 * ITEM_TARGET / 3) begin
                add_marker(1, 0, 1);
                mode = 2;
                add_marker(0, 1, 2);
            end
            i = $urandom_range(12, 2);
            if ($urandom_range(9) < 7) add_shaped(i, mode);
            else add_noise(i, mode);
            total += i;
        end
        gen_done = 1;
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(negedge i_clk) begin : drive_points
        t_point it;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_taken) begin
        end else if (point_q.size() == 0) begin
            in_valid <= 1'b0;
        end else if (point_q[0].drain || point_q[0].hold) begin
            in_valid <= 1'b0;
            if (point_q[0].hold) begin
                hold_req <= 1'b1;
                void'(point_q.pop_front());
            end else if (peak_expect_q.size() == 0) begin
                void'(point_q.pop_front());
            end
        end else if ($urandom_range(99) < (point_q[0].mode == 0 ? 29 :
                                           point_q[0].mode == 1 ? 79 : 0)) begin
            in_valid <= 1'b0;
        end else begin
            it = point_q.pop_front();
            freq_d <= it.freq;
            mag_d <= it.mag;
            last_d <= it.last;
            cur_mode <= it.mode;
            in_valid <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_cnt != 0) begin
            out_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_used) begin
            out_stall <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else begin
            out_stall <= $urandom_range(99) < (cur_mode == 0 ? 79 : cur_mode == 1 ? 29 : 0);
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_peak e;
        bit in_fire;
        bit out_fire;
        in_fire = i_rst_n && in_valid && !o_in_stall;
        out_fire = i_rst_n && o_out_valid && !out_stall;
        in_taken <= in_fire;
        if (!i_rst_n) begin
            clear_search();
        end else begin
            if (in_fire) track_point(freq_d, mag_d, last_d);
            if (out_fire) begin
                if (peak_expect_q.size() == 0) begin
                    flag_mismatch("result with no item pending");
                end else begin
                    e = peak_expect_q.pop_front();
                    if (o_raw_db !== e.raw_db)
                        flag_mismatch($sformatf("raw_db %0d exp %0d", o_raw_db, e.raw_db));
                    if (o_raw_freq !== e.raw_freq)
                        flag_mismatch($sformatf("raw_freq %0d exp %0d", o_raw_freq, e.raw_freq));
                    if (o_peak_index !== e.peak_index)
                        flag_mismatch($sformatf("peak_index %0d exp %0d",
                                                o_peak_index, e.peak_index));
                    if (o_interp_db !== e.interp_db)
                        flag_mismatch($sformatf("interp_db %0d exp %0d",
                                                o_interp_db, e.interp_db));
                    if (o_interp_freq !== e.interp_freq)
                        flag_mismatch($sformatf("interp_freq %0d exp %0d",
                                                o_interp_freq, e.interp_freq));
                    if (o_interpolated !== e.interpolated)
                        flag_mismatch($sformatf("interpolated %0b exp %0b",
                                                o_interpolated, e.interpolated));
                end
            end
            if (in_fire || out_fire) quiet_cnt <= 0;
            else quiet_cnt <= quiet_cnt + 1;
            if (quiet_cnt >= QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        do @(posedge i_clk);
        while (!(gen_done && point_q.size() == 0 && !in_valid && peak_expect_q.size() == 0));
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (peak_expect_q.size() != 0) flag_mismatch("expected result never arrived");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
